// File: rtl/sht_pkg.sv
// Shared types and constants for the scheduled heater thermostat.
package sht_pkg;

  localparam int unsigned TEMP_W   = 7;
  localparam int unsigned MINUTE_W = 11;
  localparam int unsigned CFG_W    = 29;
  localparam int unsigned COUNT_W  = 8;

  localparam logic [TEMP_W-1:0] TEMP_SAT       = 7'd99;
  localparam logic [TEMP_W-1:0] TEMP_SAT_LIMIT = 7'd100;
  localparam logic [TEMP_W-1:0] FREEZE_ON      = 7'd3;
  localparam logic [TEMP_W-1:0] FREEZE_OFF     = 7'd8;
  localparam logic [TEMP_W-1:0] HOLD_BAND      = 7'd7;
  localparam logic [TEMP_W-1:0] SETPOINT_RESET = 7'd40;

  localparam logic [3:0] MASK_TWO   = 4'h3;
  localparam logic [3:0] MASK_THREE = 4'h7;
  localparam logic [3:0] MASK_FOUR  = 4'hF;

  typedef enum logic [2:0] {
    CFG_POWER_MODE      = 3'd0,
    CFG_MANUAL_SETPOINT = 3'd1,
    CFG_WINDOW_A        = 3'd2,
    CFG_WINDOW_B        = 3'd3,
    CFG_WINDOW_C        = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    FAULT_NONE       = 3'd0,
    FAULT_LEAKAGE    = 3'd1,
    FAULT_OVERHEAT   = 3'd2,
    FAULT_WATER      = 3'd3,
    FAULT_ANTIFREEZE = 3'd4
  } fault_t;

  typedef enum logic [1:0] {
    WIN_NONE = 2'd0,
    WIN_A    = 2'd1,
    WIN_B    = 2'd2,
    WIN_C    = 2'd3
  } window_t;

  typedef struct packed {
    logic [2:0]       power_mode;
    logic [TEMP_W-1:0] manual_setpoint;
    logic [CFG_W-1:0]  window_a;
    logic [CFG_W-1:0]  window_b;
    logic [CFG_W-1:0]  window_c;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0]   water_temp;
    logic [MINUTE_W-1:0] minute_of_day;
    logic                leakage_fault;
    logic                overheat_fault;
    logic                water_fault;
  } item_t;

  typedef struct packed {
    logic               hold_off;
    logic               pump_state;
    logic               runon_armed;
    logic [COUNT_W-1:0] runon_count;
    logic               antifreeze_latch;
  } state_t;

  typedef struct packed {
    logic [3:0] switch_mask;
    logic       pump_on;
    logic       alarm_on;
    window_t    active_window;
    logic       working;
    fault_t     fault_code;
  } result_t;

endpackage

// File: rtl/sht_regulator.sv
// Per-tick thermostat decision: faults, antifreeze, windows, band and run-on.
module sht_regulator #(
  parameter logic [sht_pkg::COUNT_W-1:0] RUNON_TICKS = 8'd200
) (
  input  sht_pkg::item_t   item,
  input  sht_pkg::cfg_t    cfg,
  input  sht_pkg::state_t  state,
  output sht_pkg::state_t  state_next,
  output sht_pkg::result_t result
);

  logic [sht_pkg::TEMP_W-1:0] temp;
  logic [sht_pkg::TEMP_W-1:0] setpoint;
  logic [3:0]                 stage;
  logic                       latch_next;
  logic                       run;
  logic                       in_a, in_b, in_c;
  sht_pkg::fault_t            fault;

  function automatic logic in_window(input logic [sht_pkg::CFG_W-1:0] w,
                                     input logic [sht_pkg::MINUTE_W-1:0] now);
    logic [sht_pkg::MINUTE_W-1:0] st;
    logic [sht_pkg::MINUTE_W-1:0] et;
    st = w[10:0];
    et = w[21:11];
    if (et >= st) begin
      in_window = (now >= st) && (now < et);
    end else begin
      in_window = !((now > et) && (now < st));
    end
  endfunction

  assign temp = (item.water_temp >= sht_pkg::TEMP_SAT_LIMIT) ? sht_pkg::TEMP_SAT
                                                            : item.water_temp;
  assign latch_next = (temp < sht_pkg::FREEZE_ON) ||
                      (state.antifreeze_latch && (temp < sht_pkg::FREEZE_OFF));
  assign in_a = in_window(cfg.window_a, item.minute_of_day);
  assign in_b = in_window(cfg.window_b, item.minute_of_day);
  assign in_c = in_window(cfg.window_c, item.minute_of_day);

  always_comb begin
    case (cfg.power_mode[2:1])
      2'd0:    stage = sht_pkg::MASK_TWO;
      2'd1:    stage = sht_pkg::MASK_THREE;
      default: stage = sht_pkg::MASK_FOUR;
    endcase
  end

  always_comb begin
    if (item.leakage_fault) begin
      fault = sht_pkg::FAULT_LEAKAGE;
    end else if (item.overheat_fault) begin
      fault = sht_pkg::FAULT_OVERHEAT;
    end else if (item.water_fault) begin
      fault = sht_pkg::FAULT_WATER;
    end else if (latch_next) begin
      fault = sht_pkg::FAULT_ANTIFREEZE;
    end else begin
      fault = sht_pkg::FAULT_NONE;
    end
  end

  always_comb begin
    state_next = state;
    state_next.antifreeze_latch = latch_next;
    result = '0;
    result.fault_code = fault;
    result.active_window = sht_pkg::WIN_NONE;
    setpoint = cfg.manual_setpoint;
    run = 1'b1;

    if (fault == sht_pkg::FAULT_ANTIFREEZE) begin
      state_next.pump_state = 1'b1;
      result.switch_mask = stage;
      result.alarm_on = 1'b1;
    end else if (fault != sht_pkg::FAULT_NONE) begin
      state_next.pump_state = 1'b0;
      result.alarm_on = 1'b1;
    end else begin
      // latch just released: drop the pump before regulating
      if (state.antifreeze_latch) begin
        state_next.pump_state = 1'b0;
      end
      if (cfg.power_mode[0]) begin
        if (in_a) begin
          result.active_window = sht_pkg::WIN_A;
          setpoint = cfg.window_a[28:22];
        end else if (in_b) begin
          result.active_window = sht_pkg::WIN_B;
          setpoint = cfg.window_b[28:22];
        end else if (in_c) begin
          result.active_window = sht_pkg::WIN_C;
          setpoint = cfg.window_c[28:22];
        end else begin
          run = 1'b0;
          state_next.pump_state = 1'b0;
        end
      end
      if (run) begin
        result.working = 1'b1;
        if (temp > setpoint) begin
          state_next.runon_armed = 1'b1;
          state_next.hold_off = 1'b1;
        end else if ((setpoint >= sht_pkg::HOLD_BAND) &&
                     (temp >= setpoint - sht_pkg::HOLD_BAND) && state.hold_off) begin
          state_next.pump_state = 1'b0;
        end else begin
          state_next.hold_off = 1'b0;
          state_next.pump_state = 1'b1;
          result.switch_mask = stage;
        end
      end
      if (state_next.runon_armed) begin
        state_next.runon_count = state.runon_count + sht_pkg::COUNT_W'(1);
        if (state_next.runon_count == RUNON_TICKS) begin
          state_next.pump_state = 1'b0;
          state_next.runon_count = '0;
          state_next.runon_armed = 1'b0;
        end
      end
    end
    result.pump_on = state_next.pump_state;
  end

endmodule

// File: rtl/scheduled_heater_thermostat_top.sv
// Top level of the scheduled heater thermostat: handshakes, registers and state.
// One control tick is taken per clock cycle while item_stall is low; a request passes
// an input register, combinational compare logic (fault priority, three window checks,
// setpoint band, run-on counter) and a result register, which loads once the held
// result is taken or none is held.
// item_stall rises only when both registers hold requests and result_stall is high.
// Configuration writes are always ready and should only be made while the block is idle.
module scheduled_heater_thermostat_top #(
  parameter int unsigned RUNON_TICKS = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [28:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [6:0]  water_temp,
  input  logic [10:0] minute_of_day,
  input  logic        leakage_fault,
  input  logic        overheat_fault,
  input  logic        water_fault,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  switch_mask,
  output logic        pump_on,
  output logic        alarm_on,
  output logic [1:0]  active_window,
  output logic        working,
  output logic [2:0]  fault_code
);

  sht_pkg::cfg_t    cfg;
  sht_pkg::item_t   item;
  sht_pkg::state_t  state;
  sht_pkg::state_t  state_next;
  sht_pkg::result_t result_next;
  sht_pkg::result_t result;
  logic             item_held;
  logic             advance;
  logic             fire;

  assign cfg_ready  = 1'b1;
  assign advance    = !result_valid || !result_stall;
  assign fire       = item_held && advance;
  assign item_stall = item_held && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_mode      <= '0;
      cfg.manual_setpoint <= sht_pkg::SETPOINT_RESET;
      cfg.window_a        <= '0;
      cfg.window_b        <= '0;
      cfg.window_c        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sht_pkg::CFG_POWER_MODE:      cfg.power_mode <= cfg_data[2:0];
        sht_pkg::CFG_MANUAL_SETPOINT: cfg.manual_setpoint <= cfg_data[6:0];
        sht_pkg::CFG_WINDOW_A:        cfg.window_a <= cfg_data;
        sht_pkg::CFG_WINDOW_B:        cfg.window_b <= cfg_data;
        sht_pkg::CFG_WINDOW_C:        cfg.window_c <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (!item_stall) begin
      item_held <= item_valid;
    end
    if (item_valid && !item_stall) begin
      item.water_temp     <= water_temp;
      item.minute_of_day  <= minute_of_day;
      item.leakage_fault  <= leakage_fault;
      item.overheat_fault <= overheat_fault;
      item.water_fault    <= water_fault;
    end
  end

  sht_regulator #(
    .RUNON_TICKS(RUNON_TICKS[sht_pkg::COUNT_W-1:0])
  ) u_regulator (
    .item       (item),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        state <= state_next;
      end
      if (advance) begin
        result_valid <= item_held;
      end
    end
    if (fire) begin
      result <= result_next;
    end
  end

  assign switch_mask   = result.switch_mask;
  assign pump_on       = result.pump_on;
  assign alarm_on      = result.alarm_on;
  assign active_window = result.active_window;
  assign working       = result.working;
  assign fault_code    = result.fault_code;

`ifndef NO_ASSERTIONS
  a_runon_below_limit: assert property (@(posedge clk) disable iff (rst)
    state.runon_count < RUNON_TICKS[sht_pkg::COUNT_W-1:0])
    else $error("run-on count reached its limit without clearing");

  a_runon_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !state.runon_armed |-> state.runon_count == '0)
    else $error("run-on count non-zero while disarmed");

  a_fault_all_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && (fault_code == sht_pkg::FAULT_LEAKAGE ||
                     fault_code == sht_pkg::FAULT_OVERHEAT ||
                     fault_code == sht_pkg::FAULT_WATER)
    |-> switch_mask == 4'h0 && !pump_on && alarm_on && !working)
    else $error("outputs active during an external fault");

  a_working_no_fault: assert property (@(posedge clk) disable iff (rst)
    result_valid && working |-> fault_code == sht_pkg::FAULT_NONE && !alarm_on)
    else $error("regulator working during a fault");
`endif

endmodule
